// ===== rtl/kle_pkg.sv =====
// ----------------------------------------------------------------------------
// kle_pkg
// Types and codes shared by the keyed list engine and its storage cells.
// ----------------------------------------------------------------------------
package kle_pkg;

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_REMOVE  = 3'd1;
    localparam logic [2:0] KIND_FIND    = 3'd2;
    localparam logic [2:0] KIND_DELETE  = 3'd3;
    localparam logic [2:0] KIND_SORT    = 3'd4;
    localparam logic [2:0] KIND_REVERSE = 3'd5;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_ROTATE,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     phase;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } pair_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_value;
        logic [4:0]         entry_count;
        logic               is_empty;
    } res_t;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } fsm_state_t;

endpackage

// ===== rtl/kle_cell.sv =====
// ----------------------------------------------------------------------------
// kle_cell
// One list position: holds a key/data pair and moves it to or from its
// neighbours for push, pop, rotate and odd-even compare-exchange.
// ----------------------------------------------------------------------------
module kle_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic               clk,
    input  kle_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]      len,
    input  kle_pkg::pair_t     left,
    input  kle_pkg::pair_t     right,
    input  kle_pkg::pair_t     front,
    input  logic               left_gt,
    output kle_pkg::pair_t     q,
    output logic               gt_right
);

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);
    localparam logic          PARITY   = 1'(IDX % 2);

    kle_pkg::pair_t q_reg;
    kle_pkg::pair_t q_next;

    assign q        = q_reg;
    assign gt_right = (q_reg.value > right.value);

    always_comb
    begin
        q_next = q_reg;
        case (ctrl.op)
            kle_pkg::CELL_HOLD:   q_next = q_reg;
            kle_pkg::CELL_PUSH:   q_next = left;
            kle_pkg::CELL_POP:    q_next = right;
            kle_pkg::CELL_ROTATE:
            begin
                // last occupied position takes the front pair
                if (POS_NEXT < len)
                    q_next = right;
                else if (POS_NEXT == len)
                    q_next = front;
            end
            kle_pkg::CELL_SORT:
            begin
                if (PARITY == ctrl.phase && POS_NEXT < len && gt_right)
                    q_next = right;
                else if (PARITY != ctrl.phase && IDX != 0 && POS < len && left_gt)
                    q_next = left;
            end
            default:              q_next = q_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== rtl/keyed_list_engine.sv =====
// ----------------------------------------------------------------------------
// keyed_list_engine: ordered key/data list held in a chain of DEPTH cells.
// A new command is taken only in idle, not while one runs; find, delete and
// sort step through the pairs held and reverse rotates a shrinking prefix;
// a stalled result beat holds off the next command.
// Reset (rst_n low, async) empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module keyed_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  kle_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output kle_pkg::res_t res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    kle_pkg::fsm_state_t state_reg, state_next;

    logic [2:0]         op_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      len_reg, len_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               phase_reg, phase_next;
    logic               found_reg, found_next;
    logic signed [31:0] rk_reg, rk_next;
    logic signed [31:0] rv_reg, rv_next;
    logic               res_valid_reg, res_valid_next;
    kle_pkg::res_t      res_reg, res_next;

    logic               accept;
    logic               done;
    kle_pkg::status_t   status;
    kle_pkg::cell_ctrl_t cell_ctrl;
    kle_pkg::pair_t     new_pair;
    kle_pkg::pair_t     cell_q [DEPTH];
    logic               cell_gt [DEPTH];

    assign cmd_stall = (state_reg != kle_pkg::S_IDLE) || (res_valid_reg && res_stall);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign new_pair  = '{key: key_reg, value: value_reg};

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        kle_pkg::pair_t left_pair;
        kle_pkg::pair_t right_pair;
        logic           left_gt;

        if (i == 0)
        begin : g_first
            assign left_pair = new_pair;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_mid
            assign left_pair = cell_q[i-1];
            assign left_gt   = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_pair = cell_q[i];
        end
        else
        begin : g_inner
            assign right_pair = cell_q[i+1];
        end

        kle_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .len      (len_reg),
            .left     (left_pair),
            .right    (right_pair),
            .front    (cell_q[0]),
            .left_gt  (left_gt),
            .q        (cell_q[i]),
            .gt_right (cell_gt[i])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kle_pkg::S_IDLE: if (accept) state_next = kle_pkg::S_RUN;
            kle_pkg::S_RUN:  if (done)   state_next = kle_pkg::S_IDLE;
            default:         state_next = kle_pkg::S_IDLE;
        endcase
    end

    // One step of the running operation
    always_comb
    begin
        cell_ctrl  = '{op: kle_pkg::CELL_HOLD, phase: phase_reg};
        count_next = count_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        rk_next    = rk_reg;
        rv_next    = rv_reg;
        done       = 1'b0;
        status     = kle_pkg::STAT_OK;

        if (state_reg == kle_pkg::S_RUN)
        begin
            case (op_reg)
                kle_pkg::KIND_INSERT:
                begin
                    done = 1'b1;
                    if (count_reg == FULL_COUNT)
                        status = kle_pkg::STAT_FULL;
                    else
                    begin
                        cell_ctrl.op = kle_pkg::CELL_PUSH;
                        count_next   = count_reg + ONE;
                    end
                end
                kle_pkg::KIND_REMOVE:
                begin
                    done = 1'b1;
                    if (count_reg == '0)
                        status = kle_pkg::STAT_EMPTY;
                    else
                    begin
                        rk_next      = cell_q[0].key;
                        rv_next      = cell_q[0].value;
                        cell_ctrl.op = kle_pkg::CELL_POP;
                        count_next   = count_reg - ONE;
                    end
                end
                kle_pkg::KIND_FIND, kle_pkg::KIND_DELETE:
                begin
                    // rotate the list once round, examining the front each step
                    if (rem_reg == '0)
                    begin
                        done   = 1'b1;
                        status = found_reg ? kle_pkg::STAT_OK : kle_pkg::STAT_NOTFOUND;
                    end
                    else
                    begin
                        rem_next     = rem_reg - ONE;
                        cell_ctrl.op = kle_pkg::CELL_ROTATE;
                        if (!found_reg && cell_q[0].key == key_reg)
                        begin
                            found_next = 1'b1;
                            rk_next    = cell_q[0].key;
                            rv_next    = cell_q[0].value;
                            if (op_reg == kle_pkg::KIND_DELETE)
                            begin
                                // drop the match instead of moving it to the tail
                                cell_ctrl.op = kle_pkg::CELL_POP;
                                count_next   = count_reg - ONE;
                                len_next     = len_reg - ONE;
                            end
                        end
                    end
                end
                kle_pkg::KIND_SORT:
                begin
                    if (rem_reg == '0)
                        done = 1'b1;
                    else
                    begin
                        cell_ctrl.op = kle_pkg::CELL_SORT;
                        rem_next     = rem_reg - ONE;
                        phase_next   = !phase_reg;
                    end
                end
                kle_pkg::KIND_REVERSE:
                begin
                    // move the front to the end of a shrinking prefix
                    if (rem_reg == '0)
                        done = 1'b1;
                    else
                    begin
                        cell_ctrl.op = kle_pkg::CELL_ROTATE;
                        rem_next     = rem_reg - ONE;
                        len_next     = len_reg - ONE;
                    end
                end
                default: done = 1'b1;
            endcase
        end
    end

    // Result beat
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        if (done)
        begin
            res_valid_next       = 1'b1;
            res_next.status      = status;
            res_next.out_key     = rk_next;
            res_next.out_value   = rv_next;
            res_next.entry_count = 5'(count_next);
            res_next.is_empty    = (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kle_pkg::S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            op_reg    <= cmd.kind;
            key_reg   <= cmd.key;
            value_reg <= cmd.value;
            len_reg   <= count_reg;
            phase_reg <= 1'b0;
            found_reg <= 1'b0;
            rk_reg    <= '0;
            rv_reg    <= '0;
            if (cmd.kind == kle_pkg::KIND_REVERSE && count_reg != '0)
                rem_reg <= count_reg - ONE;
            else
                rem_reg <= count_reg;
        end
        else
        begin
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            phase_reg <= phase_next;
            found_reg <= found_next;
            rk_reg    <= rk_next;
            rv_reg    <= rv_next;
        end
    end

endmodule
